/* rtl/variable_chunk_ring_allocator_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the chunk ring allocator
// Concurrent checks that drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_CHUNK_RING_ALLOCATOR_CORE_MACROS_SVH
`define VARIABLE_CHUNK_RING_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle
`define VCRA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle
`define VCRA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

// Expression never holds
`define VCRA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error(msg);

`else

`define VCRA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VCRA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`define VCRA_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* rtl/vcra_pkg.sv */
// ----------------------------------------------------------------------------
// Chunk ring allocator package
// Ring geometry, header layout and the structs passed between modules.
// ----------------------------------------------------------------------------
package vcra_pkg;

	localparam int NUM_BLOCKS = 256;
	localparam int LINE_BYTES = 64;
	localparam int HEAD_BYTES = 8;

	localparam int IDX_W   = $clog2(NUM_BLOCKS);
	localparam int LEN_W   = IDX_W + 1;
	localparam int CUR_W   = 32;
	localparam int BYTES_W = 16;
	localparam int CMD_W   = 2;
	localparam int SCN_W   = LEN_W + 1;

	localparam int LINE_SH     = $clog2(LINE_BYTES);
	localparam int SUM_W       = BYTES_W + 1;
	localparam int NEED_W      = SUM_W - LINE_SH;
	localparam int HALF_BLOCKS = NUM_BLOCKS / 2;

	localparam int IN_BITS     = BYTES_W + CUR_W + LEN_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = CUR_W + IDX_W + BYTES_W + 2 * LEN_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [CMD_W-1:0]   cmd_t;
	typedef logic [1:0]         status_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [CUR_W-1:0]   cur_t;
	typedef logic [BYTES_W-1:0] bytes_t;

	localparam cmd_t CMD_ALLOC     = 2'd0;
	localparam cmd_t CMD_COMMIT_WR = 2'd1;
	localparam cmd_t CMD_READ      = 2'd2;
	localparam cmd_t CMD_COMMIT_RD = 2'd3;

	localparam status_t ST_UNUSED  = 2'd0;
	localparam status_t ST_USED    = 2'd1;
	localparam status_t ST_INVALID = 2'd2;

	typedef struct packed {
		status_t status;
		len_t    blocks;
		bytes_t  bytes;
	} hdr_t;

	typedef struct packed {
		logic en;
		idx_t idx;
	} hdr_rd_t;

	typedef struct packed {
		logic en;
		idx_t idx;
		hdr_t data;
	} hdr_wr_t;

	typedef struct packed {
		cmd_t   cmd;
		bytes_t req_bytes;
		cur_t   chunk_cursor;
		len_t   chunk_len;
	} item_t;

	typedef struct packed {
		logic   ok;
		cur_t   out_cursor;
		idx_t   start_block;
		bytes_t payload_bytes;
		len_t   out_len;
		len_t   free_blocks;
	} res_t;

endpackage

/* rtl/vcra_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vcra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/vcra_hdr_store.sv */
// ----------------------------------------------------------------------------
// Chunk header store
// Header RAM plus one valid bit per entry; an unwritten entry reads as zero.
// ----------------------------------------------------------------------------
module vcra_hdr_store (
	input  logic              clk,
	input  logic              arst_n,
	input  vcra_pkg::hdr_rd_t rd,
	input  vcra_pkg::hdr_wr_t wr,
	output vcra_pkg::hdr_t    rd_data
);

	logic [vcra_pkg::NUM_BLOCKS-1:0] vld_q;
	logic                            rd_vld_s1;
	logic [$bits(vcra_pkg::hdr_t)-1:0] ram_rdata;

	vcra_ram #(
		.WIDTH ($bits(vcra_pkg::hdr_t)),
		.DEPTH (vcra_pkg::NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (rd.en),
		.raddr (rd.idx),
		.rdata (ram_rdata)
	);

	// mark entries written since reset; capture validity alongside the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_s1 <= vld_q[rd.idx];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? vcra_pkg::hdr_t'(ram_rdata) : '0;

endmodule

/* rtl/vcra_ctrl.sv */
// ----------------------------------------------------------------------------
// Chunk ring allocator controller
// Command sequencer: header read-modify-write, cursors and result build.
// ----------------------------------------------------------------------------
`include "variable_chunk_ring_allocator_core_macros.svh"

module vcra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vcra_pkg::item_t   in_item,
	output logic              res_valid,
	input  logic              res_ready,
	output vcra_pkg::res_t    res,
	output vcra_pkg::hdr_rd_t hdr_rd,
	output vcra_pkg::hdr_wr_t hdr_wr,
	input  vcra_pkg::hdr_t    rd_hdr
);

	typedef enum logic [2:0] {
		IDLE,
		AL_CHK,
		CW_RD,
		CW_WR,
		CR_WR,
		SC_RD,
		SC_EV,
		DONE
	} state_t;

	state_t                      state_q;
	vcra_pkg::item_t             item_q;
	vcra_pkg::res_t              res_q;
	vcra_pkg::cur_t              wr_q;
	vcra_pkg::cur_t              rd_q;
	vcra_pkg::cur_t              pos_q;
	vcra_pkg::len_t              need_q;
	logic [vcra_pkg::SCN_W-1:0]  scanned_q;
	logic                        retry_q;

	logic [vcra_pkg::SUM_W-1:0]  sum_in;
	logic [vcra_pkg::NEED_W-1:0] need_in;
	logic                        need_fit;
	vcra_pkg::cur_t              room;
	logic                        no_space;
	vcra_pkg::idx_t              s_idx;
	vcra_pkg::idx_t              e_idx;
	logic                        contig;
	vcra_pkg::len_t              pad_len;
	vcra_pkg::idx_t              cur_idx;
	vcra_pkg::len_t              skip_len;
	logic [vcra_pkg::SCN_W-1:0]  scn_next;
	vcra_pkg::cur_t              used_cnt;
	vcra_pkg::len_t              free_cnt;

	always_comb begin
		sum_in   = vcra_pkg::SUM_W'(in_item.req_bytes)
			+ vcra_pkg::SUM_W'(vcra_pkg::HEAD_BYTES + vcra_pkg::LINE_BYTES - 1);
		need_in  = sum_in[vcra_pkg::SUM_W-1:vcra_pkg::LINE_SH];
		need_fit = (need_in != '0) && (need_in <= vcra_pkg::NEED_W'(vcra_pkg::HALF_BLOCKS));

		room     = wr_q + vcra_pkg::CUR_W'(need_q) - rd_q;
		no_space = room > vcra_pkg::CUR_W'(vcra_pkg::NUM_BLOCKS);
		s_idx    = wr_q[vcra_pkg::IDX_W-1:0];
		e_idx    = s_idx + need_q[vcra_pkg::IDX_W-1:0];
		contig   = (e_idx == '0) || (s_idx < e_idx);
		pad_len  = vcra_pkg::len_t'(vcra_pkg::NUM_BLOCKS) - vcra_pkg::len_t'(s_idx);
		cur_idx  = item_q.chunk_cursor[vcra_pkg::IDX_W-1:0];

		// padding skips by its length (at least one), any other code by one
		skip_len = ((rd_hdr.status == vcra_pkg::ST_INVALID) && (rd_hdr.blocks != '0))
			? rd_hdr.blocks : vcra_pkg::len_t'(1);
		scn_next = scanned_q + vcra_pkg::SCN_W'(skip_len);

		used_cnt = wr_q - rd_q;
		free_cnt = (used_cnt >= vcra_pkg::CUR_W'(vcra_pkg::NUM_BLOCKS)) ? '0
			: vcra_pkg::len_t'(vcra_pkg::NUM_BLOCKS) - used_cnt[vcra_pkg::LEN_W-1:0];

		hdr_rd = '0;
		hdr_wr = '0;
		case (state_q)
			AL_CHK: begin
				if (!no_space) begin
					hdr_wr.en  = 1'b1;
					hdr_wr.idx = s_idx;
					if (contig) begin
						hdr_wr.data.status = vcra_pkg::ST_UNUSED;
						hdr_wr.data.blocks = need_q;
						hdr_wr.data.bytes  = item_q.req_bytes;
					end else begin
						hdr_wr.data.status = vcra_pkg::ST_INVALID;
						hdr_wr.data.blocks = pad_len;
						hdr_wr.data.bytes  = '0;
					end
				end
			end
			CW_RD: begin
				hdr_rd.en  = 1'b1;
				hdr_rd.idx = cur_idx;
			end
			CW_WR: begin
				hdr_wr.en          = 1'b1;
				hdr_wr.idx         = cur_idx;
				hdr_wr.data.status = vcra_pkg::ST_USED;
				hdr_wr.data.blocks = rd_hdr.blocks;
				hdr_wr.data.bytes  = rd_hdr.bytes;
			end
			CR_WR: begin
				hdr_wr.en  = 1'b1;
				hdr_wr.idx = cur_idx;
			end
			SC_RD: begin
				hdr_rd.en  = 1'b1;
				hdr_rd.idx = pos_q[vcra_pkg::IDX_W-1:0];
			end
			default: begin
			end
		endcase

		res             = res_q;
		res.free_blocks = free_cnt;
	end

	assign in_ready  = (state_q == IDLE);
	assign res_valid = (state_q == DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			item_q    <= '0;
			res_q     <= '0;
			wr_q      <= '0;
			rd_q      <= '0;
			pos_q     <= '0;
			need_q    <= '0;
			scanned_q <= '0;
			retry_q   <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						item_q    <= in_item;
						res_q     <= '0;
						retry_q   <= 1'b0;
						scanned_q <= '0;
						pos_q     <= rd_q;
						need_q    <= vcra_pkg::len_t'(need_in);
						case (in_item.cmd)
							vcra_pkg::CMD_ALLOC:     state_q <= need_fit ? AL_CHK : DONE;
							vcra_pkg::CMD_COMMIT_WR: state_q <= CW_RD;
							vcra_pkg::CMD_READ:      state_q <= SC_RD;
							vcra_pkg::CMD_COMMIT_RD: state_q <= CR_WR;
							default:                 state_q <= DONE;
						endcase
					end
				end
				AL_CHK: begin
					if (no_space) begin
						state_q <= DONE;
					end else if (contig) begin
						wr_q                <= wr_q + vcra_pkg::CUR_W'(need_q);
						res_q.ok            <= 1'b1;
						res_q.out_cursor    <= wr_q;
						res_q.start_block   <= s_idx;
						res_q.payload_bytes <= item_q.req_bytes;
						res_q.out_len       <= need_q;
						state_q             <= DONE;
					end else begin
						// padding written; retry once from the ring start
						wr_q    <= wr_q + vcra_pkg::CUR_W'(pad_len);
						retry_q <= 1'b1;
						if (retry_q) begin
							state_q <= DONE;
						end
					end
				end
				CW_RD: begin
					state_q <= CW_WR;
				end
				CW_WR: begin
					res_q.ok          <= 1'b1;
					res_q.out_cursor  <= item_q.chunk_cursor;
					res_q.start_block <= cur_idx;
					state_q           <= DONE;
				end
				CR_WR: begin
					rd_q              <= item_q.chunk_cursor + vcra_pkg::CUR_W'(item_q.chunk_len);
					res_q.ok          <= 1'b1;
					res_q.out_cursor  <= item_q.chunk_cursor;
					res_q.start_block <= cur_idx;
					state_q           <= DONE;
				end
				SC_RD: begin
					state_q <= SC_EV;
				end
				SC_EV: begin
					case (rd_hdr.status)
						vcra_pkg::ST_USED: begin
							if (rd_hdr.blocks != '0) begin
								res_q.ok            <= 1'b1;
								res_q.out_cursor    <= pos_q;
								res_q.start_block   <= pos_q[vcra_pkg::IDX_W-1:0];
								res_q.payload_bytes <= rd_hdr.bytes;
								res_q.out_len       <= rd_hdr.blocks;
							end
							state_q <= DONE;
						end
						vcra_pkg::ST_UNUSED: begin
							state_q <= DONE;
						end
						default: begin
							pos_q     <= pos_q + vcra_pkg::CUR_W'(skip_len);
							scanned_q <= scn_next;
							state_q   <= (scn_next < vcra_pkg::SCN_W'(vcra_pkg::NUM_BLOCKS))
								? SC_RD : DONE;
						end
					endcase
				end
				DONE: begin
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`VCRA_ASSERT_NEVER(a_rd_wr_excl, clk, arst_n, hdr_rd.en && hdr_wr.en, "header read and write in one cycle")

	`VCRA_ASSERT_NEVER(a_idle_done_excl, clk, arst_n, in_ready && res_valid, "accepting while a result is pending")

	`VCRA_ASSERT_IMP(a_pad_len, clk, arst_n, hdr_wr.en && (hdr_wr.data.status == vcra_pkg::ST_INVALID), (vcra_pkg::len_t'(hdr_wr.idx) + hdr_wr.data.blocks) == vcra_pkg::len_t'(vcra_pkg::NUM_BLOCKS), "padding does not reach the ring end")

	`VCRA_ASSERT_IMP(a_alloc_len, clk, arst_n, res_valid && res.ok && (item_q.cmd == vcra_pkg::CMD_ALLOC), (res.out_len != '0) && (res.out_len <= vcra_pkg::len_t'(vcra_pkg::HALF_BLOCKS)), "granted chunk length out of range")

	`VCRA_ASSERT_NXT(a_pad_retry, clk, arst_n, hdr_wr.en && (hdr_wr.data.status == vcra_pkg::ST_INVALID), (state_q == AL_CHK) || (state_q == DONE), "padding write not followed by retry")

endmodule

/* rtl/variable_chunk_ring_allocator_core.sv */
// ----------------------------------------------------------------------------
// Variable-length chunk ring allocator core
// One command at a time: alloc writes the chunk header if there is room, or on
// a ring wrap first padding to the ring end and then retries once; commit write
// reads and rewrites the header; commit read clears it and advances the read
// cursor; read visits headers, skipping padding. A new command is taken in the
// cycle after the result moves to the output register. One header read port.
// Reset (arst_n low): cursors zero, header valid bits clear at once, no sweep.
// ----------------------------------------------------------------------------
module variable_chunk_ring_allocator_core (
	input  logic                                clk,
	input  logic                                arst_n,

	// command transactions
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [15:0] req_bytes, [47:16] chunk_cursor, [56:48] chunk_len, rest zero
	input  logic [vcra_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] cmd
	input  logic [vcra_pkg::CMD_W-1:0]          s_axis_tuser,

	// result transactions
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] out_cursor, [39:32] start_block, [55:40] payload_bytes,
	// [64:56] out_len, [73:65] free_blocks, rest zero
	output logic [vcra_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// [0] ok
	output logic                                m_axis_tuser
);

	vcra_pkg::item_t   in_item;
	vcra_pkg::res_t    res;
	logic              res_valid;
	logic              res_ready;
	vcra_pkg::hdr_rd_t hdr_rd;
	vcra_pkg::hdr_wr_t hdr_wr;
	vcra_pkg::hdr_t    rd_hdr;

	vcra_pkg::res_t    out_q;
	logic              out_vld_q;

	// Unpack the slave transaction: command travels on tuser, the operands
	// are packed into tdata from bit 0 upward.
	always_comb begin
		in_item.cmd          = s_axis_tuser;
		in_item.req_bytes    = s_axis_tdata[vcra_pkg::BYTES_W-1:0];
		in_item.chunk_cursor = s_axis_tdata[vcra_pkg::BYTES_W +: vcra_pkg::CUR_W];
		in_item.chunk_len    = s_axis_tdata[vcra_pkg::BYTES_W + vcra_pkg::CUR_W +: vcra_pkg::LEN_W];
	end

	// Sequencer: owns the write and read cursors and walks each command
	// through its header accesses.
	vcra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.hdr_rd    (hdr_rd),
		.hdr_wr    (hdr_wr),
		.rd_hdr    (rd_hdr)
	);

	// Header memory: status, block count and payload size per ring block.
	vcra_hdr_store u_hdr_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (hdr_rd),
		.wr      (hdr_wr),
		.rd_data (rd_hdr)
	);

	// Output register: parts the sequencer from the master side, so the
	// sequencer is free for the next command while a result waits here.
	assign res_ready = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (res_ready) begin
				out_vld_q <= res_valid;
				if (res_valid) begin
					out_q <= res;
				end
			end
		end
	end

	// Pack the result: ok on tuser, the rest on tdata from bit 0 upward.
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.ok;
	assign m_axis_tdata  = vcra_pkg::OUT_TDATA_W'({
		out_q.free_blocks,
		out_q.out_len,
		out_q.payload_bytes,
		out_q.start_block,
		out_q.out_cursor
	});

endmodule
